// ===== rtl/core/ecbd_pkg.sv =====
// ----------------------------------------------------------------------------
// ecbd_pkg: shared definitions for the Elias code bit decoder
// Widths, register indexes, code modes, status codes and the word types that
// pass between the front end, the bit engine and the top level.
// ----------------------------------------------------------------------------
package ecbd_pkg;

	// value width and saturation limit
	localparam int VALUE_BITS = 32;
	localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam logic [31:0] VMAX = 32'((64'd1 << VW) - 64'd1);

	// byte geometry
	localparam int BYTE_BITS = 8;
	localparam int RAW_BITS  = 8;

	// queue between front end and bit engine
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PREFIX_MAX = 2'd1;
	localparam logic [2:0] CODE_MODE_RST  = 3'd0;
	localparam logic [7:0] PREFIX_MAX_RST = 8'd255;

	// code modes
	localparam logic [2:0] MODE_UNARY = 3'd0;
	localparam logic [2:0] MODE_TRUNC = 3'd1;
	localparam logic [2:0] MODE_GAMMA = 3'd2;
	localparam logic [2:0] MODE_DELTA = 3'd3;
	localparam logic [2:0] MODE_RAW   = 3'd4;

	// result status codes
	localparam logic [1:0] ST_DECODED   = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_CLEAN_END = 2'd2;
	localparam logic [1:0] ST_CUT_SHORT = 2'd3;

	// decoding phase of a gamma or delta code
	typedef enum logic [2:0] {
		PH_PREFIX = 3'b001,
		PH_SUFFIX = 3'b010,
		PH_TAIL   = 3'b100
	} phase_t;

	// classified input byte
	typedef struct packed {
		logic [7:0] byte_in;
		logic [3:0] nbits;
		logic       last_byte;
	} entry_t;

	// configuration seen by the bit engine
	typedef struct packed {
		logic [2:0] code_mode;
		logic [7:0] prefix_max;
		logic       clear;
	} ctrl_t;

	// one result word
	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
		logic [3:0]  bit_count;
		logic        run_last;
	} result_t;

endpackage

// ===== rtl/core/ecbd_ifs.sv =====
// ----------------------------------------------------------------------------
// ecbd_ifs: channel interfaces of the Elias code bit decoder
// Byte input channel, result output channel and configuration write channel,
// each a valid/ready handshake with a source and a sink modport.
// ----------------------------------------------------------------------------
interface ecbd_in_if import ecbd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       last_byte;

	modport source (output valid, output byte_in, output last_byte, input ready);
	modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface ecbd_out_if import ecbd_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic [1:0]  status;
	logic [3:0]  bit_count;
	logic        run_last;

	modport source (output valid, output value, output status, output bit_count,
		output run_last, input ready);
	modport sink   (input valid, input value, input status, input bit_count,
		input run_last, output ready);
endinterface

interface ecbd_cfg_if import ecbd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ecbd_front.sv =====
// ----------------------------------------------------------------------------
// ecbd_front: byte intake and classification
// Finds the number of code bits in each byte (stop marker on the final byte)
// and holds classified bytes in a short queue for the bit engine.
// ----------------------------------------------------------------------------
module ecbd_front import ecbd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	ecbd_in_if.sink       byte_ch,
	output entry_t        q_head,
	output logic          q_valid,
	input  logic          q_pop
);

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic [3:0]          nbits;
	logic                q_push;

	// lowest set bit of a final byte is the stop marker
	always_comb begin
		nbits = 4'(BYTE_BITS);
		if (byte_ch.last_byte) begin
			nbits = 4'd0;
			for (int p = BYTE_BITS - 1; p >= 0; p--) begin
				if (byte_ch.byte_in[p]) begin
					nbits = 4'(BYTE_BITS - 1 - p);
				end
			end
		end
	end

	assign byte_ch.ready = (cnt_q != QCNT_W'(QDEPTH));
	assign q_push        = byte_ch.valid && byte_ch.ready;
	assign q_valid       = (cnt_q != '0);
	assign q_head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_push) begin
			mem_q[wr_ptr_q] <= '{byte_in: byte_ch.byte_in, nbits: nbits,
				last_byte: byte_ch.last_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (q_push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (q_pop && !q_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/ecbd_back.sv =====
// ----------------------------------------------------------------------------
// ecbd_back: bit engine and result staging
// Decodes one code bit per cycle from the queue head unless stalled, holds the
// newest result until it is known if it closes its byte, then registers it.
// ----------------------------------------------------------------------------
module ecbd_back import ecbd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  entry_t        q_head,
	input  logic          q_valid,
	output logic          q_pop,
	input  ctrl_t         ctrl,
	ecbd_out_if.source    out_ch
);

	// engine state
	phase_t       phase_q;
	logic [31:0]  ones_q;
	logic [31:0]  acc_q;
	logic [31:0]  rem_q;
	logic         ovf_q;
	logic         ended_q;
	// byte walk
	logic [3:0]   bidx_q;
	logic         end_done_q;
	// staging
	logic         pend_valid_q;
	result_t      pend_q;
	logic         out_valid_q;
	result_t      out_q;

	// next engine state of one bit
	phase_t       n_phase;
	logic [31:0]  n_ones;
	logic [31:0]  n_acc;
	logic [31:0]  n_rem;
	logic         n_ovf;
	logic         res_v;
	result_t      res;
	logic         clr;

	logic [2:0]   m;
	logic [31:0]  cap;
	logic         b;
	logic [31:0]  ones_inc;
	logic [31:0]  sh_acc;
	logic         sh_ovf;
	logic [31:0]  rem_dec;
	logic [31:0]  raw_base;
	logic [31:0]  raw_acc;

	result_t      end_res;
	logic         end_cut;
	logic [3:0]   end_cnt;

	logic         out_free;
	logic         step_bit;
	logic         step_end;
	logic         step_fin;
	logic         new_res_v;
	result_t      new_res;
	logic         stall;
	logic         push;
	result_t      push_data;
	logic         advance;

	always_comb begin
		m        = (ctrl.code_mode > MODE_RAW) ? MODE_RAW : ctrl.code_mode;
		cap      = (ctrl.prefix_max == 8'd0) ? 32'd1 : {24'd0, ctrl.prefix_max};
		b        = q_head.byte_in[~bidx_q[2:0]];
		ones_inc = (ones_q == '1) ? ones_q : ones_q + 32'd1;
		if (ovf_q || (acc_q > (VMAX >> 1))) begin
			sh_acc = VMAX;
			sh_ovf = 1'b1;
		end else begin
			sh_acc = {acc_q[30:0], b};
			sh_ovf = ovf_q;
		end
		rem_dec  = rem_q - 32'd1;
		raw_base = (ones_q == '0) ? 32'd0 : acc_q;
		raw_acc  = {raw_base[30:0], b};

		n_phase = phase_q;
		n_ones  = ones_q;
		n_acc   = acc_q;
		n_rem   = rem_q;
		n_ovf   = ovf_q;
		res_v   = 1'b0;
		res     = '0;
		clr     = 1'b0;

		unique case (m) inside
			MODE_UNARY: begin
				if (b) begin
					n_ones = ones_inc;
				end else begin
					res_v = 1'b1;
					clr   = 1'b1;
					if (ones_q >= VMAX) begin
						res.value  = VMAX;
						res.status = ST_OVERFLOW;
					end else begin
						res.value  = ones_q + 32'd1;
						res.status = ST_DECODED;
					end
				end
			end
			MODE_TRUNC: begin
				if (b) begin
					if (ones_inc >= cap) begin
						res_v     = 1'b1;
						res.value = cap;
						clr       = 1'b1;
					end else begin
						n_ones = ones_inc;
					end
				end else begin
					res_v     = 1'b1;
					res.value = ones_q;
					clr       = 1'b1;
				end
			end
			MODE_GAMMA, MODE_DELTA: begin
				if (phase_q == PH_PREFIX) begin
					if (b) begin
						n_ones = ones_inc;
					end else if (ones_q == '0) begin
						res_v     = 1'b1;
						res.value = 32'd1;
						clr       = 1'b1;
					end else begin
						n_phase = PH_SUFFIX;
						n_rem   = ones_q;
						n_acc   = 32'd1;
						n_ones  = '0;
					end
				end else if (rem_dec != '0) begin
					n_acc = sh_acc;
					n_ovf = sh_ovf;
					n_rem = rem_dec;
				end else if ((m == MODE_DELTA) && (phase_q == PH_SUFFIX)) begin
					// gamma part done: read its value less one further bits
					n_rem   = sh_acc - 32'd1;
					n_acc   = 32'd1;
					n_ovf   = sh_ovf;
					n_phase = PH_TAIL;
				end else begin
					res_v      = 1'b1;
					res.value  = sh_acc;
					res.status = sh_ovf ? ST_OVERFLOW : ST_DECODED;
					clr        = 1'b1;
				end
			end
			default: begin
				n_acc  = raw_acc;
				n_ones = ones_q + 32'd1;
				if (ones_q >= 32'(RAW_BITS - 1)) begin
					res_v         = 1'b1;
					res.value     = {24'd0, raw_acc[7:0]};
					res.bit_count = 4'(RAW_BITS);
					clr           = 1'b1;
				end
			end
		endcase

		if (clr) begin
			n_phase = PH_PREFIX;
			n_ones  = '0;
			n_acc   = 32'd1;
			n_rem   = '0;
			n_ovf   = 1'b0;
		end
	end

	// end-of-stream status
	always_comb begin
		end_cut = (phase_q != PH_PREFIX) || (ones_q != '0);
		end_cnt = '0;
		end_res = '0;
		if (end_cut) begin
			end_res.status = ST_CUT_SHORT;
			if (m == MODE_RAW) begin
				end_cnt = (ones_q > 32'(RAW_BITS)) ? 4'(RAW_BITS) : ones_q[3:0];
				end_res.value     = acc_q & ((32'd1 << end_cnt) - 32'd1);
				end_res.bit_count = end_cnt;
			end
		end else begin
			end_res.status = ST_CLEAN_END;
		end
	end

	// sequencing of the head byte
	always_comb begin
		out_free  = !out_valid_q || out_ch.ready;
		step_bit  = q_valid && !ended_q && (bidx_q < q_head.nbits);
		step_end  = q_valid && !ended_q && !step_bit && q_head.last_byte && !end_done_q;
		step_fin  = q_valid && !ended_q && !step_bit && !step_end;
		new_res_v = (step_bit && res_v) || step_end;
		new_res   = step_bit ? res : end_res;
		stall     = pend_valid_q && !out_free && (new_res_v || step_fin);
		push      = !stall && pend_valid_q && (new_res_v || step_fin);
		push_data = pend_q;
		push_data.run_last = step_fin;
		q_pop     = q_valid && (ended_q || (step_fin && !stall));
		advance   = (step_bit || step_end) && !stall;
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.value     = out_q.value;
	assign out_ch.status    = out_q.status;
	assign out_ch.bit_count = out_q.bit_count;
	assign out_ch.run_last  = out_q.run_last;

	always_ff @(posedge clk) begin
		if (advance && new_res_v) begin
			pend_q <= new_res;
		end
		if (push) begin
			out_q <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_PREFIX;
			ones_q       <= '0;
			acc_q        <= 32'd1;
			rem_q        <= '0;
			ovf_q        <= 1'b0;
			ended_q      <= 1'b0;
			bidx_q       <= '0;
			end_done_q   <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctrl.clear || (advance && step_end)) begin
				phase_q <= PH_PREFIX;
				ones_q  <= '0;
				acc_q   <= 32'd1;
				rem_q   <= '0;
				ovf_q   <= 1'b0;
			end else if (advance) begin
				phase_q <= n_phase;
				ones_q  <= n_ones;
				acc_q   <= n_acc;
				rem_q   <= n_rem;
				ovf_q   <= n_ovf;
			end
			if (advance && step_bit) begin
				bidx_q <= bidx_q + 4'd1;
			end
			if (advance && step_end) begin
				end_done_q <= 1'b1;
			end
			if (step_fin && !stall) begin
				bidx_q     <= '0;
				end_done_q <= 1'b0;
				ended_q    <= q_head.last_byte;
			end
			if (advance && new_res_v) begin
				pend_valid_q <= 1'b1;
			end else if (push) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a finished stream leaves nothing staged
	a_ended_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> !pend_valid_q)
		else $error("result still staged after end of stream");

	// the walk never passes the code bits of the head byte
	a_bidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && !ended_q) |-> (bidx_q <= q_head.nbits))
		else $error("bit index beyond code bits of byte");

	// the closing word of a byte goes out only as its byte is released
	a_run_last_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.run_last) |-> q_pop)
		else $error("closing word sent without releasing its byte");

	// a word is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_valid_q) |-> out_ch.ready)
		else $error("output word overwritten while stalled");

endmodule

// ===== rtl/core/elias_code_bit_decoder_unit.sv =====
// Throughput: the one-bit-per-cycle engine walks the code bits of each byte unless
// stalled, then releases the byte; the final byte also gets a step for its end status.
// Bytes after the end of the stream are dropped at one per cycle.
// Reset: code_mode 0, prefix_max 255, queue and staging empty, decoder in its
// prefix phase with no stream ended.
// ----------------------------------------------------------------------------
// elias_code_bit_decoder_unit: universal code bit decoder, top level
// Front end classifies stream bytes into a short queue; the bit engine decodes
// unary, truncated unary, gamma, delta or raw codes one bit per cycle unless stalled.
// ----------------------------------------------------------------------------
module elias_code_bit_decoder_unit import ecbd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	ecbd_in_if.sink       byte_ch,
	ecbd_out_if.source    result_ch,
	ecbd_cfg_if.sink      cfg
);

	// configuration registers
	logic [2:0]  code_mode_q;
	logic [7:0]  prefix_max_q;

	// queue between front end and bit engine
	entry_t      q_head;
	logic        q_valid;
	logic        q_pop;
	ctrl_t       ctrl;

	// configuration is always taken at once
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_mode_q  <= CODE_MODE_RST;
			prefix_max_q <= PREFIX_MAX_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CODE_MODE:  code_mode_q  <= cfg.data[2:0];
				REG_PREFIX_MAX: prefix_max_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// a mode write drops any code in progress
	assign ctrl.code_mode  = code_mode_q;
	assign ctrl.prefix_max = prefix_max_q;
	assign ctrl.clear      = cfg.valid && (cfg.index == REG_CODE_MODE);

	// intake: classify each byte and queue it
	ecbd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.q_head  (q_head),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	// bit engine: decode, stage and register result words
	ecbd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_head),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.ctrl    (ctrl),
		.out_ch  (result_ch)
	);

endmodule

// ===== verif/ecbd_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ecbd_tb_pkg: word predictor and checker for the Elias code bit decoder
// Keeps its own copy of the decoder state and registers, turns every accepted
// stream byte into the words it must cause, and checks arriving words in order.
// ----------------------------------------------------------------------------
package ecbd_tb_pkg;
	import ecbd_pkg::*;

	class word_checker;
		logic [2:0]  mode;
		logic [7:0]  pmax;
		phase_t      phase;
		logic [31:0] ones;
		logic [31:0] acc;
		logic [31:0] sfx;
		bit          ovf;
		bit          ended;
		result_t     pending_words[$];
		int          errors;

		function new();
			mode   = CODE_MODE_RST;
			pmax   = PREFIX_MAX_RST;
			ended  = 0;
			errors = 0;
			clear_code();
		endfunction

		function void clear_code();
			phase = PH_PREFIX;
			ones  = '0;
			acc   = 32'd1;
			sfx   = '0;
			ovf   = 0;
		endfunction

		function void add_word(logic [31:0] v, logic [1:0] st, logic [3:0] bc);
			result_t w;
			w.value     = v;
			w.status    = st;
			w.bit_count = bc;
			w.run_last  = 1'b0;
			pending_words.push_back(w);
		endfunction

		function void count_one();
			if (ones != '1)
				ones++;
		endfunction

		// one code bit through the selected decoder
		function void decode_bit(bit b);
			logic [2:0] m;
			logic [7:0] cap;
			m   = (mode > MODE_RAW) ? MODE_RAW : mode;
			cap = (pmax != 0) ? pmax : 8'd1;
			if (m == MODE_UNARY) begin
				if (b) begin
					count_one();
					return;
				end
				if ({1'b0, ones} + 33'd1 > {1'b0, VMAX})
					add_word(VMAX, ST_OVERFLOW, 4'd0);
				else
					add_word(ones + 32'd1, ST_DECODED, 4'd0);
				clear_code();
			end else if (m == MODE_TRUNC) begin
				if (b) begin
					count_one();
					if (ones >= {24'd0, cap}) begin
						add_word({24'd0, cap}, ST_DECODED, 4'd0);
						clear_code();
					end
					return;
				end
				add_word(ones, ST_DECODED, 4'd0);
				clear_code();
			end else if (m == MODE_RAW) begin
				acc = (((ones == 0) ? 32'd0 : acc) << 1) | {31'd0, b};
				ones++;
				if (ones >= 32'd8) begin
					add_word(acc & 32'hFF, ST_DECODED, 4'd8);
					clear_code();
				end
			end else if (phase == PH_PREFIX) begin
				if (b) begin
					count_one();
					return;
				end
				if (ones == 0) begin
					add_word(32'd1, ST_DECODED, 4'd0);
					clear_code();
					return;
				end
				phase = PH_SUFFIX;
				sfx   = ones;
				acc   = 32'd1;
				ones  = '0;
			end else begin
				// shift a suffix bit in, saturating once the value no longer fits
				if (ovf || acc > (VMAX >> 1)) begin
					ovf = 1;
					acc = VMAX;
				end else begin
					acc = {acc[30:0], b};
				end
				sfx--;
				if (sfx != 0)
					return;
				if (m == MODE_DELTA && phase == PH_SUFFIX) begin
					// gamma part done: its value sets the tail length
					sfx   = acc - 32'd1;
					acc   = 32'd1;
					phase = PH_TAIL;
					return;
				end
				add_word(acc, ovf ? ST_OVERFLOW : ST_DECODED, 4'd0);
				clear_code();
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_CODE_MODE) begin
				mode = data[2:0];
				clear_code();
			end else if (idx == REG_PREFIX_MAX) begin
				pmax = data;
			end
		endfunction

		// note an accepted stream byte and queue the words it causes
		function void take_byte(logic [7:0] b, logic last);
			int nbits;
			int p;
			int n0;
			int cnt;
			logic [31:0] v;
			if (ended)
				return;
			n0    = pending_words.size();
			nbits = 8;
			if (last) begin
				if (b == 0) begin
					nbits = 0;
				end else begin
					p = 0;
					while (!b[p])
						p++;
					nbits = 7 - p;
				end
			end
			for (int i = 0; i < nbits; i++)
				decode_bit(b[7 - i]);
			if (last) begin
				if (phase != PH_PREFIX || ones != 0) begin
					cnt = 0;
					v   = '0;
					if (mode >= MODE_RAW) begin
						cnt = (ones > 32'd8) ? 8 : int'(ones);
						v   = acc & ((32'd1 << cnt) - 32'd1);
					end
					add_word(v, ST_CUT_SHORT, 4'(cnt));
				end else begin
					add_word('0, ST_CLEAN_END, 4'd0);
				end
				clear_code();
				ended = 1;
			end
			if (pending_words.size() > n0)
				pending_words[pending_words.size() - 1].run_last = 1'b1;
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (pending_words.size() == 0) begin
				$error("unexpected word: value %h status %0d bit_count %0d run_last %0b",
					got.value, got.status, got.bit_count, got.run_last);
				errors++;
				return;
			end
			want = pending_words.pop_front();
			if (got.value !== want.value) begin
				$error("value: expected %h, got %h", want.value, got.value);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.bit_count !== want.bit_count) begin
				$error("bit_count: expected %0d, got %0d", want.bit_count, got.bit_count);
				errors++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
				errors++;
			end
		endfunction

		function bit drained();
			return pending_words.size() == 0;
		endfunction
	endclass

endpackage

// ===== verif/tb_elias_code_bit_decoder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_elias_code_bit_decoder_unit: testbench of the Elias code bit decoder
// Drives one byte stream through every code mode and several register settings, with
// directed corner bytes then random bytes under changing idle and stall
// patterns, and checks every word against an in-house predictor.
// ----------------------------------------------------------------------------
module tb_elias_code_bit_decoder_unit;
	import ecbd_pkg::*;
	import ecbd_tb_pkg::*;

	// modes without a defined code; they decode as raw bytes
	localparam logic [2:0] MODE_UNDEF_5 = 3'd5;
	localparam logic [2:0] MODE_UNDEF_6 = 3'd6;
	localparam logic [2:0] MODE_UNDEF_7 = 3'd7;

	// register indexes with nothing behind them
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;

	// cycles to let the engine finish bytes that cause no word
	localparam int SETTLE_CYCLES = 64;
	// cycles with no handshake at all before the run is declared hung
	localparam int HANG_LIMIT    = 5000;
	localparam int RAND_PHASES   = 12;
	localparam int PHASE_BYTES   = 27;

	logic clk;
	logic arst_n;

	ecbd_in_if  in_ch();
	ecbd_out_if out_ch();
	ecbd_cfg_if cfg_ch();

	elias_code_bit_decoder_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (in_ch),
		.result_ch (out_ch),
		.cfg       (cfg_ch)
	);

	word_checker board = new();

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int hang_count = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: decide ready afresh on every falling edge
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(1, 100) > snk_stall_pct);
		end
	end

	// collect words at the rising edge and hand them to the checker
	always @(posedge clk) begin : collect
		result_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.value     = out_ch.value;
			got.status    = out_ch.status;
			got.bit_count = out_ch.bit_count;
			got.run_last  = out_ch.run_last;
			board.check_word(got);
		end
	end

	// watchdog: count cycles where no channel moves a word
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			hang_count <= 0;
		end else if (hang_count >= HANG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			hang_count <= hang_count + 1;
		end
	end

	// offer one byte; valid stays high into the next call unless a gap is drawn
	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(1, 100) <= src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.byte_in   <= b;
		in_ch.last_byte <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		board.take_byte(b, last);
	endtask

	// write one register; only called with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		board.write_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// mode write with random junk above the three mode bits
	task automatic set_mode(input logic [2:0] m);
		write_reg(REG_CODE_MODE, {5'($urandom_range(0, 31)), m});
	endtask

	// drop valid, wait for every expected word, then let the engine go quiet
	task automatic drain_and_settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (!board.drained())
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int profile);
		case (profile)
			0: begin
				src_idle_pct  = 0;
				snk_stall_pct = 0;
			end
			1: begin
				src_idle_pct  = 52;
				snk_stall_pct = 0;
			end
			2: begin
				src_idle_pct  = 0;
				snk_stall_pct = 52;
			end
			default: begin
				src_idle_pct  = 8;
				snk_stall_pct = 8;
			end
		endcase
	endtask

	// stream content: plain random bytes, runs of ones or zeros, sparse bytes.
	// Delta mode avoids long runs of ones, which would mean very long tails.
	function automatic logic [7:0] stream_byte(input logic [2:0] m);
		int r;
		logic [7:0] a;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		a = 8'($urandom_range(0, 255));
		b = 8'($urandom_range(0, 255));
		if (m == MODE_DELTA)
			return (r < 70) ? a : (a & b);
		if (r < 50)
			return a;
		if (r < 65)
			return 8'hFF;
		if (r < 80)
			return 8'h00;
		return a & b;
	endfunction

	initial begin : stimulus
		logic [2:0] phase_mode [RAND_PHASES];
		logic [2:0] m;
		logic [7:0] pm;
		logic [7:0] fin;

		// drive every input to a known value from time zero
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.byte_in    = '0;
		in_ch.last_byte  = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.data      = '0;

		phase_mode = '{MODE_UNARY, MODE_TRUNC, MODE_GAMMA, MODE_DELTA, MODE_RAW,
			MODE_UNDEF_5, MODE_TRUNC, MODE_DELTA, MODE_UNDEF_6, MODE_UNDEF_7,
			MODE_GAMMA, MODE_TRUNC};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_idling(0);

		// unary with the reset settings: a zero byte gives eight words
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		drain_and_settle();

		// truncated unary with a zero cap, which acts as a cap of one
		set_mode(MODE_TRUNC);
		write_reg(REG_PREFIX_MAX, 8'd0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h0F, 1'b0);
		drain_and_settle();

		// lowered cap: count ones under the widest cap, then shrink it
		write_reg(REG_PREFIX_MAX, 8'd255);
		send_byte(8'hFF, 1'b0);
		drain_and_settle();
		write_reg(REG_PREFIX_MAX, 8'd3);
		send_byte(8'h80, 1'b0);
		drain_and_settle();

		// writes to unmapped indexes must change nothing
		write_reg(REG_UNMAPPED_2, 8'hFF);
		write_reg(REG_UNMAPPED_3, 8'h00);

		// gamma: shortest codes, then a 32-one prefix that saturates
		set_mode(MODE_GAMMA);
		send_byte(8'h00, 1'b0);
		repeat (4) send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b0);
		repeat (3) send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		// leave a gamma code half read; the mode write below drops it
		send_byte(8'hF0, 1'b0);
		drain_and_settle();

		// delta: shortest codes, then a length of 36 whose tail overflows
		set_mode(MODE_DELTA);
		send_byte(8'h00, 1'b0);
		send_byte(8'hF8, 1'b0);
		send_byte(8'h80, 1'b0);
		repeat (4) send_byte(8'hFF, 1'b0);
		drain_and_settle();

		// raw bytes, and an undefined mode that decodes as raw
		set_mode(MODE_RAW);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h3C, 1'b0);
		drain_and_settle();
		set_mode(MODE_UNDEF_7);
		send_byte(8'h5A, 1'b0);
		drain_and_settle();

		// random phases: every mode under rotating idle patterns
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			set_idling(ph % 4);
			pm = (ph == 1) ? 8'd255 : (ph == 6) ? 8'd1 : 8'($urandom_range(1, 255));
			set_mode(phase_mode[ph]);
			write_reg(REG_PREFIX_MAX, pm);
			repeat (PHASE_BYTES) send_byte(stream_byte(phase_mode[ph]), 1'b0);
			drain_and_settle();
		end

		// closing phase: a random mode, then the final byte with its stop marker
		set_idling(3);
		m = 3'($urandom_range(0, 7));
		set_mode(m);
		write_reg(REG_PREFIX_MAX, 8'($urandom_range(1, 255)));
		repeat (8) send_byte(stream_byte(m), 1'b0);
		fin = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
		send_byte(fin, 1'b1);
		// bytes after the end are dropped without a word
		repeat (4) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		drain_and_settle();

		if (board.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== elias_code_bit_decoder_unit.f =====
rtl/core/ecbd_pkg.sv
rtl/core/ecbd_ifs.sv
rtl/core/ecbd_front.sv
rtl/core/ecbd_back.sv
rtl/core/elias_code_bit_decoder_unit.sv
verif/ecbd_tb_pkg.sv
verif/tb_elias_code_bit_decoder_unit.sv
